/* design/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* design/bis_pkg.sv */
package bis_pkg;
  localparam int unsigned CH_W  = 16;
  localparam int unsigned PIX_W = 64;
  localparam int unsigned CRD_W = 18;
  // weights scaled by 2^25, signed; range fits 27 bits
  localparam int unsigned WGT_W = 27;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef wgt_t wvec_t [4];

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MATH = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Catmull-Rom weights for fraction t in 1/256 units
  function automatic wgt_t weight(input logic [7:0] t, input logic [1:0] k);
    logic signed [40:0] tt, t2, t3, r;
    begin
      tt = $signed({33'd0, t});
      t2 = tt * tt;
      t3 = t2 * tt;
      case (k)
        2'd0: r = -t3 + 41'sd512 * t2 - 41'sd65536 * tt;
        2'd1: r = 41'sd3 * t3 - 41'sd1280 * t2 + (41'sd1 <<< 25);
        2'd2: r = -41'sd3 * t3 + 41'sd1024 * t2 + 41'sd65536 * tt;
        default: r = t3 - 41'sd256 * t2;
      endcase
      weight = r[WGT_W-1:0];
    end
  endfunction
endpackage

/* design/bis_filter.sv */
// Per-channel separable accumulator: one pixel per cycle in x while en is high, row fold in y
module bis_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          en,
  input  logic [1:0]                    col,
  input  logic [bis_pkg::CH_W-1:0]      pix,
  input  bis_pkg::wgt_t                 wx,
  input  bis_pkg::wgt_t                 wy,
  output logic [bis_pkg::CH_W-1:0]      res
);
  logic signed [46:0] row_r, row_nxt, prod_x;
  logic signed [46:0] rowd_r;
  bis_pkg::wgt_t      wyd_r;
  logic               fold_r;
  logic signed [26:0] rh;
  logic signed [20:0] rl;
  logic signed [53:0] pa;
  logic signed [47:0] pb;
  logic signed [57:0] a_r, a_nxt, c_sum, v_sh;
  logic signed [51:0] b_r, b_nxt, b_rnd;

  // x product into the row accumulator
  always_comb begin
    prod_x  = $signed({1'b0, pix}) * wx;
    row_nxt = (col == 2'd0 ? 47'sd0 : row_r) + prod_x;
  end

  // y fold in the cycle after a row completes; row split into high and low parts
  always_comb begin
    rh    = rowd_r[46:20];
    rl    = $signed({1'b0, rowd_r[19:0]});
    pa    = rh * wyd_r;
    pb    = rl * wyd_r;
    a_nxt = a_r + 58'(pa);
    b_nxt = b_r + 52'(pb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      row_r  <= '0;
      rowd_r <= '0;
      wyd_r  <= '0;
      fold_r <= 1'b0;
      a_r    <= '0;
      b_r    <= '0;
    end else begin
      fold_r <= en && (col == 2'd3);
      if (en) row_r <= row_nxt;
      if (en && col == 2'd3) begin
        rowd_r <= row_nxt;
        wyd_r  <= wy;
      end
      if (fold_r) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
      end
    end
  end

  // exact sum scaled 2^50: round half up then clamp
  always_comb begin
    b_rnd = b_r + (52'sd1 <<< 49);
    c_sum = a_r + 58'(b_rnd >>> 20);
    v_sh  = c_sum >>> 30;
    if (v_sh < 0) res = '0;
    else if (v_sh > 58'sd65535) res = '1;
    else res = v_sh[bis_pkg::CH_W-1:0];
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_clr_en, clr && en, "filter clear during accumulate")
  `ASSERT_IMPL(a_clr_zero, clr |=> (a_r == 0 && b_r == 0), "accumulator not cleared")
  `ASSERT_IMPL(a_hold, (!fold_r && !clr) |=> ($stable(a_r) && $stable(b_r)), "accumulator moved while idle")
endmodule

/* design/bicubic_image_sampler_unit.sv */
// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | kind, pixel xy/rgba, sample xy
// out      | out_valid/out_ready| rgba, clipped
// cfg      | cfg_we             | cfg_index, cfg_data
// Writes can follow back to back.
// A sample holds off the input after acceptance: 16 memory reads, one per cycle
// on the single image memory port (ST_READ), then the last row is folded
// (ST_MATH) and the result is registered (ST_DONE), which raises out_valid.
// Reset is synchronous; the image memory holds no reset value.
// The result stays in its output register until taken; the next item is
// accepted the cycle after it has gone.
module bicubic_image_sampler_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [15:0] in_pixel_red,
  input  logic [15:0] in_pixel_green,
  input  logic [15:0] in_pixel_blue,
  input  logic [15:0] in_pixel_alpha,
  input  logic signed [17:0] in_sample_x,
  input  logic signed [17:0] in_sample_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic        out_clipped,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned SW = 13;

  bis_pkg::state_t st_r, st_nxt;
  logic [8:0] wd_r, ht_r;
  logic [SW-1:0] effw, effh;

  logic [bis_pkg::PIX_W-1:0] mem [2**AW];
  logic [bis_pkg::PIX_W-1:0] rd_r;

  logic signed [SW-1:0] cx_r, cy_r;
  logic [7:0] tx_r, ty_r;
  logic [3:0] rcnt_r, pcnt_r;
  logic       pv_r, clip_r;
  logic [15:0] ored_r, ogrn_r, oblu_r, oalp_r;
  logic        oclip_r;
  bis_pkg::wgt_t wx_r, wy_r;

  // effective image size
  always_comb begin
    effw = (wd_r == 9'd0) ? SW'(1) :
           ({4'd0, wd_r} > SW'(MAX_WIDTH) ? SW'(MAX_WIDTH) : SW'(wd_r));
    effh = (ht_r == 9'd0) ? SW'(1) :
           ({4'd0, ht_r} > SW'(MAX_HEIGHT) ? SW'(MAX_HEIGHT) : SW'(ht_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r <= 9'd256;
      ht_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == bis_pkg::CFG_WIDTH) wd_r <= cfg_data;
      else ht_r <= cfg_data;
    end
  end

  assign in_ready = (st_r == bis_pkg::ST_IDLE) && !out_valid;
  logic acc_in;
  assign acc_in = in_valid && in_ready;

  // neighbour address for current read
  logic signed [SW-1:0] nx, ny;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic clip_now;
  always_comb begin
    nx = cx_r + SW'($signed({1'b0, rcnt_r[1:0]})) - SW'(1);
    ny = cy_r + SW'($signed({1'b0, rcnt_r[3:2]})) - SW'(1);
    clip_now = 1'b0;
    if (nx < 0) begin ax = '0; clip_now = 1'b1; end
    else if (nx > $signed(effw - SW'(1))) begin
      ax = XW'(effw - SW'(1)); clip_now = 1'b1;
    end else ax = nx[XW-1:0];
    if (ny < 0) begin ay = '0; clip_now = 1'b1; end
    else if (ny > $signed(effh - SW'(1))) begin
      ay = YW'(effh - SW'(1)); clip_now = 1'b1;
    end else ay = ny[YW-1:0];
  end

  // image memory: one write or one read per cycle
  logic wr_en;
  assign wr_en = acc_in && in_kind == bis_pkg::KIND_WRITE &&
                 SW'(in_pixel_x) < SW'(MAX_WIDTH) &&
                 SW'(in_pixel_y) < SW'(MAX_HEIGHT);
  always_ff @(posedge clk) begin
    if (wr_en)
      mem[{AW'(in_pixel_y) << XW} | AW'(in_pixel_x)] <=
        {in_pixel_alpha, in_pixel_blue, in_pixel_green, in_pixel_red};
    if (st_r == bis_pkg::ST_READ) rd_r <= mem[{ay, ax}];
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bis_pkg::ST_IDLE: if (acc_in && in_kind == bis_pkg::KIND_SAMPLE) st_nxt = bis_pkg::ST_READ;
      bis_pkg::ST_READ: if (rcnt_r == 4'd15) st_nxt = bis_pkg::ST_MATH;
      bis_pkg::ST_MATH: if (!pv_r) st_nxt = bis_pkg::ST_DONE;
      bis_pkg::ST_DONE: st_nxt = bis_pkg::ST_IDLE;
      default: st_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // coordinate minus half a pixel, one bit wider so the low end does not wrap
  logic signed [18:0] sx_m, sy_m;
  assign sx_m = 19'(in_sample_x) - 19'sd128;
  assign sy_m = 19'(in_sample_y) - 19'sd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bis_pkg::ST_IDLE;
      rcnt_r <= '0;
      pv_r <= 1'b0;
      clip_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pv_r <= (st_r == bis_pkg::ST_READ);
      if (st_r == bis_pkg::ST_READ) begin
        rcnt_r <= rcnt_r + 4'd1;
        clip_r <= clip_r | clip_now;
      end
      if (acc_in) begin
        rcnt_r <= '0;
        clip_r <= 1'b0;
      end
      if (st_r == bis_pkg::ST_DONE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // weights registered alongside the pixel they belong to
  always_ff @(posedge clk) begin
    if (acc_in) begin
      cx_r <= SW'(sx_m >>> 8);
      cy_r <= SW'(sy_m >>> 8);
      tx_r <= sx_m[7:0];
      ty_r <= sy_m[7:0];
    end
    if (st_r == bis_pkg::ST_READ) begin
      pcnt_r <= rcnt_r;
      wx_r   <= bis_pkg::weight(tx_r, rcnt_r[1:0]);
      wy_r   <= bis_pkg::weight(ty_r, rcnt_r[3:2]);
    end
  end

  logic [15:0] res [4];
  for (genvar c = 0; c < 4; c++) begin : g_ch
    bis_filter u_f (
      .clk(clk), .rst_n(rst_n), .clr(acc_in), .en(pv_r),
      .col(pcnt_r[1:0]), .pix(rd_r[16*c +: 16]), .wx(wx_r), .wy(wy_r), .res(res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (st_r == bis_pkg::ST_DONE) begin
      ored_r <= res[0]; ogrn_r <= res[1]; oblu_r <= res[2]; oalp_r <= res[3];
      oclip_r <= clip_r;
    end
  end
  assign out_red = ored_r;
  assign out_green = ogrn_r;
  assign out_blue = oblu_r;
  assign out_alpha = oalp_r;
  assign out_clipped = oclip_r;

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_acc_busy, acc_in && st_r != bis_pkg::ST_IDLE, "item taken while busy")
  `ASSERT_IMPL(a_done_out, (st_r == bis_pkg::ST_DONE) |=> out_valid, "result not raised")
  `ASSERT_IMPL(a_rd_cnt, (st_r == bis_pkg::ST_MATH) |-> (rcnt_r == 4'd0), "read count off")
endmodule
